// ===== sv/dbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbfr_pkg
// Shared types and constants for the bi-phase frame receiver.
// ----------------------------------------------------------------------------
package dbfr_pkg;

  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned WinW       = CfgW + 1;
  localparam int unsigned RawW       = 26;
  localparam int unsigned CountW     = 5;
  localparam int unsigned InfoW      = 10;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned KindW      = 5;
  localparam int unsigned ButtonW    = 3;
  localparam int unsigned EventW     = 24;
  localparam int unsigned OutDataW   = 64;

  localparam int unsigned MaxFrameBitsDefault = 26;
  localparam int unsigned MinEmitBits         = 16;
  localparam int unsigned QueueDepth          = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegHalfBit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFullBit  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTol      = 2'd2;
  localparam logic [CfgIdxW-1:0] RegEofGap   = 2'd3;

  localparam logic [CfgW-1:0] HalfBitReset = 16'd417;
  localparam logic [CfgW-1:0] FullBitReset = 16'd833;
  localparam logic [CfgW-1:0] TolReset     = 16'd100;
  localparam logic [CfgW-1:0] EofGapReset  = 16'd2000;

  // Request kinds on tuser
  localparam logic ReqEdge  = 1'b0;
  localparam logic ReqCheck = 1'b1;

  localparam logic [KindW-1:0]   PushButtonKind = 5'd1;
  localparam logic [3:0]         LastButtonCode = 4'd6;
  localparam logic [ButtonW-1:0] NoButton       = 3'd7;

  // Classified item from the front end
  typedef struct packed {
    logic is_check;
    logic level;      // line level after the edge
    logic is_half;
    logic is_full;
    logic gap_over;   // idle gap beyond end of frame
  } token_t;

  typedef struct packed {
    logic [ButtonW-1:0] button_code;
    logic               instance_select;
    logic [KindW-1:0]   instance_kind;
    logic [AddrW-1:0]   source_address;
    logic [InfoW-1:0]   evt_info;
    logic               evt_flag;
    logic [RawW-1:0]    raw_bits;
    logic [CountW-1:0]  bit_count;
  } result_t;

endpackage

// ===== sv/dali_biphase_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// dali_biphase_frame_receiver
// Passive bi-phase frame receiver driven by bus edge timestamps.
// ----------------------------------------------------------------------------
// Each input word is either a bus edge or a time check (tuser), with a 32-bit
// microsecond timestamp in tdata. The block takes one word per clock while
// the output is not stalled: a classifier measures the interval since the
// last edge and matches it against the half-bit, full-bit and end-of-frame
// limits combinationally, a two-entry queue carries the result to the frame
// engine, and the engine updates the frame for each word. The time check that
// closes a frame of 16 or more bits passes through the queue, and the frame
// appears on the master side from the output register, held until taken; only
// a stall there backs up into the queue and then the slave side.
// ----------------------------------------------------------------------------
module dali_biphase_frame_receiver #(
  parameter int unsigned MAX_FRAME_BITS = dbfr_pkg::MaxFrameBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dbfr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dbfr_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dbfr_pkg::TimeW-1:0]        s_axis_tdata,  // [31:0] time_us
  input  logic                              s_axis_tuser,  // [0] req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [4:0] bit_count, [30:5] raw_bits, [31] evt_flag, [41:32] evt_info,
  // [47:42] source_address, [52:48] instance_kind, [53] instance_select,
  // [56:54] button_code, [63:57] zero
  output logic [dbfr_pkg::OutDataW-1:0]     m_axis_tdata
);
  import dbfr_pkg::*;

  token_t  fe_tok, q_tok;
  logic    fe_valid, fe_ready, q_valid, q_ready;
  result_t result;

  dbfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .time_us_i   (s_axis_tdata),
    .tok_valid_o (fe_valid),
    .tok_ready_i (fe_ready),
    .tok_o       (fe_tok)
  );

  dbfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_tok_i   (fe_tok),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_tok_o    (q_tok)
  );

  dbfr_back #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_ready_o (q_ready),
    .tok_i       (q_tok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = OutDataW'(result);

endmodule

// ===== sv/dbfr_front.sv =====
// ----------------------------------------------------------------------------
// dbfr_front
// Holds the timing registers, tracks edge time and line level, and classes
// each incoming word into a token for the frame engine.
// ----------------------------------------------------------------------------
module dbfr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dbfr_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [dbfr_pkg::TimeW-1:0]    time_us_i,
  output logic                          tok_valid_o,
  input  logic                          tok_ready_i,
  output dbfr_pkg::token_t              tok_o
);
  import dbfr_pkg::*;

  logic [CfgW-1:0]  half_q, full_q, tol_q, eof_q;
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic             level_q, level_d;
  logic [TimeW-1:0] dt;
  logic [WinW-1:0]  half_hi, full_hi;
  logic [CfgW-1:0]  half_lo, full_lo;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfBitReset;
      full_q <= FullBitReset;
      tol_q  <= TolReset;
      eof_q  <= EofGapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHalfBit: half_q <= cfg_wdata_i;
        RegFullBit: full_q <= cfg_wdata_i;
        RegTol:     tol_q  <= cfg_wdata_i;
        RegEofGap:  eof_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Window bounds; lower bound saturates at zero
  assign half_lo = (half_q >= tol_q) ? half_q - tol_q : '0;
  assign full_lo = (full_q >= tol_q) ? full_q - tol_q : '0;
  assign half_hi = {1'b0, half_q} + {1'b0, tol_q};
  assign full_hi = {1'b0, full_q} + {1'b0, tol_q};

  assign in_ready_o  = tok_ready_i;
  assign tok_valid_o = in_valid_i;
  assign accept      = in_valid_i && tok_ready_i;

  assign dt = time_us_i - last_edge_q;

  always_comb begin
    tok_o.is_check = (req_type_i == ReqCheck);
    tok_o.level    = ~level_q;
    tok_o.is_half  = (dt >= TimeW'(half_lo)) && (dt <= TimeW'(half_hi));
    tok_o.is_full  = (dt >= TimeW'(full_lo)) && (dt <= TimeW'(full_hi));
    tok_o.gap_over = (dt > TimeW'(eof_q));
  end

  always_comb begin
    last_edge_d = last_edge_q;
    level_d     = level_q;
    if (accept && req_type_i == ReqEdge) begin
      last_edge_d = time_us_i;
      level_d     = ~level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      level_q     <= 1'b1;
    end else begin
      last_edge_q <= last_edge_d;
      level_q     <= level_d;
    end
  end

endmodule

// ===== sv/dbfr_queue.sv =====
// ----------------------------------------------------------------------------
// dbfr_queue
// Two-entry token queue between the classifier and the frame engine.
// ----------------------------------------------------------------------------
module dbfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  dbfr_pkg::token_t push_tok_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output dbfr_pkg::token_t pop_tok_o
);
  import dbfr_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  token_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ===== sv/dbfr_back.sv =====
// ----------------------------------------------------------------------------
// dbfr_back
// Frame engine: decodes bits from classified tokens, closes frames and
// holds the finished frame in an output register.
// ----------------------------------------------------------------------------
module dbfr_back #(
  parameter int unsigned MAX_FRAME_BITS = dbfr_pkg::MaxFrameBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  output logic              tok_ready_o,
  input  dbfr_pkg::token_t  tok_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dbfr_pkg::result_t out_o
);
  import dbfr_pkg::*;

  localparam int unsigned BitsW = $clog2(MAX_FRAME_BITS + 2);

  logic                      recv_q, recv_d;
  logic [MAX_FRAME_BITS-1:0] shift_q, shift_d;
  logic [BitsW-1:0]          bits_q, bits_d;
  logic                      phase_q, phase_d;
  logic                      out_valid_q, out_valid_d;
  result_t                   out_q, out_d;
  logic                      pop, take, emit;
  logic [RawW+MAX_FRAME_BITS-1:0] raw_ext;
  logic [EventW-1:0]         raw24;
  logic [InfoW-1:0]          info;
  logic [KindW-1:0]          kind;

  assign tok_ready_o = !out_valid_q || out_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;

  assign raw_ext = {{RawW{1'b0}}, shift_q};
  assign raw24   = shift_q[EventW-1:0];
  assign info    = raw24[InfoW-1:0];
  assign kind    = raw24[15:11];

  always_comb begin
    recv_d  = recv_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    phase_d = phase_q;
    take    = 1'b0;
    emit    = 1'b0;
    if (pop) begin
      if (!tok_i.is_check) begin
        if (!recv_q) begin
          if (!tok_i.level) begin
            recv_d  = 1'b1;
            shift_d = '0;
            bits_d  = '0;
            phase_d = 1'b0;
          end
        end else if (!tok_i.is_half && !tok_i.is_full) begin
          recv_d  = 1'b0;
          shift_d = '0;
          bits_d  = '0;
          phase_d = 1'b0;
        end else begin
          if (tok_i.is_full) begin
            take    = 1'b1;
            phase_d = 1'b0;
          end else begin
            phase_d = ~phase_q;
            take    = ~phase_q;
          end
          if (take) begin
            shift_d = {shift_q[MAX_FRAME_BITS-2:0], ~tok_i.level};
            bits_d  = bits_q + 1'b1;
          end
          // Drop a runaway frame
          if (bits_d > BitsW'(MAX_FRAME_BITS)) begin
            recv_d  = 1'b0;
            shift_d = '0;
            bits_d  = '0;
            phase_d = 1'b0;
          end
        end
      end else if (recv_q && tok_i.gap_over) begin
        emit    = (bits_q >= BitsW'(MinEmitBits));
        recv_d  = 1'b0;
        shift_d = '0;
        bits_d  = '0;
        phase_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_d             = '0;
    out_d.bit_count   = bits_q[CountW-1:0];
    out_d.raw_bits    = raw_ext[RawW-1:0];
    out_d.button_code = NoButton;
    if (bits_q == BitsW'(EventW)) begin
      out_d.evt_flag        = 1'b1;
      out_d.evt_info        = info;
      out_d.source_address  = raw24[22:17];
      out_d.instance_kind   = kind;
      out_d.instance_select = raw24[10];
      if (kind == PushButtonKind && info[3:0] <= LastButtonCode) begin
        out_d.button_code = info[ButtonW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q      <= 1'b0;
      shift_q     <= '0;
      bits_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      recv_q      <= recv_d;
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== test/tb_dali_biphase_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_dali_biphase_frame_receiver
// Self-checking bench for the bi-phase frame receiver.
// ----------------------------------------------------------------------------
// Feeds edge and time-check words built from encoded frames, broken frames and
// noise. A built-in frame decoder tracks the line, predicts every closed frame
// and checks each output word field by field. Runs over several timing
// settings, including extremes, with random stalls on both sides and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_dali_biphase_frame_receiver;
  import dbfr_pkg::*;

  localparam int unsigned MaxFrameBits = MaxFrameBitsDefault;
  localparam int          CycleLimit   = 400000;
  localparam int          DrainCycles  = 20;
  localparam int          HoldCycles   = 600;
  localparam logic        PickHalf     = 1'b1;
  localparam logic        PickFull     = 1'b0;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [TimeW-1:0]    s_axis_tdata;   // [31:0] time_us
  logic                s_axis_tuser;   // [0] req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [4:0] bit_count, [30:5] raw_bits, [31] evt_flag, [41:32] evt_info,
  // [47:42] source_address, [52:48] instance_kind, [53] instance_select,
  // [56:54] button_code, [63:57] zero
  logic [OutDataW-1:0] m_axis_tdata;

  dali_biphase_frame_receiver #(
    .MAX_FRAME_BITS(MaxFrameBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Timing registers as the decoder sees them
  logic [CfgW-1:0] cfg_half, cfg_full, cfg_tol, cfg_eof;

  // Frame decoder state
  logic [31:0] fr_last_edge;
  logic        fr_level;
  logic        fr_receiving;
  logic [31:0] fr_shift;
  int unsigned fr_bits;
  logic        fr_half_phase;

  result_t due_frames[$];

  // Directed rows may carry a typed-in expectation alongside the word
  logic    pend_typed, pend_emit;
  result_t pend_res;
  logic    drv_typed, drv_typed_emit;
  result_t drv_typed_res;

  // Generator's view of the bus
  logic [31:0] gen_time, gen_last;
  logic        gen_level;
  int          gen_edge_idx, gen_bad_pos;

  int src_idle_pct, dst_idle_pct;
  int hold_pending = 0;
  int hold_left = 0;
  int words_sent = 0;
  int frames_checked = 0;
  int stall_cycles = 0;
  int settings_count = 1;
  int failures = 0;
  int cycle_count = 0;

  typedef struct {
    logic        req;
    logic [31:0] t;
    logic        typed;
    logic        emit;
    result_t     res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic frame_clear();
    fr_receiving  = 1'b0;
    fr_shift      = '0;
    fr_bits       = 0;
    fr_half_phase = 1'b0;
  endtask

  function automatic logic in_window(logic [31:0] dt, logic [CfgW-1:0] nominal);
    logic [31:0] lo, hi;
    lo = (nominal >= cfg_tol) ? 32'(nominal) - 32'(cfg_tol) : 32'd0;
    hi = 32'(nominal) + 32'(cfg_tol);
    return (dt >= lo) && (dt <= hi);
  endfunction

  // Advance the decoder by one word; report a closed frame if one results
  task automatic decode_word(input logic req, input logic [31:0] t,
                             output logic emit, output result_t res);
    logic [31:0] dt;
    logic        hit_half, hit_full;
    logic [23:0] ev;
    emit = 1'b0;
    res  = '0;
    if (req == ReqEdge) begin
      dt = t - fr_last_edge;
      fr_last_edge = t;
      fr_level = !fr_level;
      if (!fr_receiving) begin
        // only a falling edge opens a frame
        if (!fr_level) begin
          frame_clear();
          fr_receiving = 1'b1;
        end
      end else begin
        hit_half = in_window(dt, cfg_half);
        hit_full = in_window(dt, cfg_full);
        if (!hit_half && !hit_full) begin
          frame_clear();
        end else begin
          if (hit_full) begin
            fr_shift = {fr_shift[30:0], !fr_level};
            fr_bits++;
            fr_half_phase = 1'b0;
          end else begin
            fr_half_phase = !fr_half_phase;
            if (fr_half_phase) begin
              fr_shift = {fr_shift[30:0], !fr_level};
              fr_bits++;
            end
          end
          if (fr_bits > MaxFrameBits) frame_clear();
        end
      end
    end else if (fr_receiving && (t - fr_last_edge) > 32'(cfg_eof)) begin
      if (fr_bits < MinEmitBits) begin
        frame_clear();
      end else begin
        emit = 1'b1;
        res.bit_count   = fr_bits[CountW-1:0];
        res.raw_bits    = fr_shift[RawW-1:0];
        res.button_code = NoButton;
        if (fr_bits == EventW) begin
          ev = fr_shift[23:0];
          res.evt_flag        = 1'b1;
          res.evt_info        = ev[9:0];
          res.source_address  = ev[22:17];
          res.instance_kind   = ev[15:11];
          res.instance_select = ev[10];
          if (ev[15:11] == PushButtonKind && ev[3:0] <= LastButtonCode)
            res.button_code = ev[2:0];
        end
        frame_clear();
      end
    end
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // Output sink: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_pending != 0) begin
      hold_left = HoldCycles;
      hold_pending = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Monitor: retire output words first, then predict the accepted input word
  always @(posedge clk_i) begin
    result_t got, due, pred;
    logic    emit;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (due_frames.size() == 0) begin
          $error("frame word with no frame due: %h", m_axis_tdata);
          failures++;
        end else begin
          due = due_frames.pop_front();
          check_field("bit_count", due.bit_count, got.bit_count);
          check_field("raw_bits", due.raw_bits, got.raw_bits);
          check_field("evt_flag", due.evt_flag, got.evt_flag);
          check_field("evt_info", due.evt_info, got.evt_info);
          check_field("source_address", due.source_address, got.source_address);
          check_field("instance_kind", due.instance_kind, got.instance_kind);
          check_field("instance_select", due.instance_select, got.instance_select);
          check_field("button_code", due.button_code, got.button_code);
          frames_checked++;
        end
      end
      if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_word(s_axis_tuser, s_axis_tdata, emit, pred);
        if (drv_typed) begin
          emit = drv_typed_emit;
          pred = drv_typed_res;
        end
        if (emit) due_frames.push_back(pred);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("dali_biphase_frame_receiver verification failed");
    $finish;
  end

  // Offer one word, with an optional idle gap first; return at acceptance
  task automatic send_word(input logic req, input logic [31:0] t);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid  <= 1'b1;
    s_axis_tuser   <= req;
    s_axis_tdata   <= t;
    drv_typed      <= pend_typed;
    drv_typed_emit <= pend_emit;
    drv_typed_res  <= pend_res;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (req == ReqEdge) begin
      gen_level = !gen_level;
      gen_last  = t;
    end
    gen_time = t;
  endtask

  function automatic logic [31:0] pick_interval(logic [CfgW-1:0] nominal);
    logic [31:0] lo, hi;
    int          r;
    lo = (nominal >= cfg_tol) ? 32'(nominal) - 32'(cfg_tol) : 32'd0;
    hi = 32'(nominal) + 32'(cfg_tol);
    r = $urandom_range(9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  task automatic frame_edge(input logic pick);
    logic [31:0] dt, top, lo_half;
    top = 32'((cfg_half > cfg_full) ? cfg_half : cfg_full) + 32'(cfg_tol) + 1;
    lo_half = (cfg_half > cfg_tol) ? 32'(cfg_half) - 32'(cfg_tol) : 32'd0;
    if (gen_edge_idx == gen_bad_pos) begin
      // push the interval outside both windows
      if (lo_half > 0 && $urandom_range(1) == 1) dt = $urandom_range(lo_half - 1, 0);
      else dt = top + $urandom_range(1000);
    end else begin
      dt = pick_interval((pick == PickHalf) ? cfg_half : cfg_full);
    end
    gen_edge_idx++;
    // a check inside the gap limit must not disturb the frame
    if ($urandom_range(99) < 3) send_word(ReqCheck, gen_last + $urandom_range(cfg_eof));
    send_word(ReqEdge, gen_last + dt);
  endtask

  // Encode nbits of want, first bit from bit nbits-1, then close the frame
  task automatic send_frame(input int nbits, input logic [31:0] want, input int bad_pos);
    int   i;
    logic b, c;
    want[nbits-1] = 1'b0;  // the first bit after the start edge is always 0
    gen_edge_idx = 0;
    gen_bad_pos  = bad_pos;
    send_word(ReqCheck, gen_last + cfg_eof + 1 + $urandom_range(40));
    if (!gen_level) send_word(ReqEdge, gen_time + $urandom_range(5000, 1));
    send_word(ReqEdge, gen_time + $urandom_range(5000, 1));
    i = 0;
    while (i < nbits) begin
      b = want[nbits-1-i];
      if (i == nbits - 1) begin
        if ($urandom_range(1) == 1) begin
          frame_edge(PickFull);
        end else begin
          frame_edge(PickHalf);
          frame_edge(PickHalf);
        end
        i++;
      end else begin
        c = want[nbits-2-i];
        if (c == b) begin
          // hold the level: two half-bit edges
          frame_edge(PickHalf);
          frame_edge(PickHalf);
          i++;
        end else if ($urandom_range(1) == 1 && ((i + 2 >= nbits) || want[nbits-3-i] == b)) begin
          frame_edge(PickHalf);
          frame_edge(PickFull);
          i += 2;
        end else begin
          frame_edge(PickFull);
          i++;
        end
      end
    end
    if ($urandom_range(3) == 0) send_word(ReqCheck, gen_last + $urandom_range(cfg_eof));
    send_word(ReqCheck, gen_last + cfg_eof + 1 + $urandom_range(40));
  endtask

  task automatic run_episode();
    int          r, nbits, n, span;
    logic [31:0] want, t;
    r = $urandom_range(99);
    if (r < 70) begin
      r = $urandom_range(99);
      if (r < 40) nbits = 24;
      else if (r < 55) nbits = 16;
      else if (r < 65) nbits = $urandom_range(26, 25);
      else nbits = $urandom_range(26, 16);
      want = $urandom;
      if (nbits == 24 && $urandom_range(1) == 1) begin
        want[15:11] = PushButtonKind;
        want[3:0]   = $urandom_range(15);
      end
      send_frame(nbits, want, -1);
    end else if (r < 85) begin
      r = $urandom_range(2);
      if (r == 0) begin
        send_frame($urandom_range(15, 1), $urandom, -1);
      end else if (r == 1) begin
        send_frame($urandom_range(31, 27), $urandom, -1);
      end else begin
        nbits = $urandom_range(26, 16);
        send_frame(nbits, $urandom, $urandom_range(nbits - 1));
      end
    end else begin
      n = $urandom_range(6, 1);
      span = 2 * int'(cfg_full) + int'(cfg_tol) + int'(cfg_eof);
      repeat (n) begin
        if ($urandom_range(99) < 30) t = $urandom;
        else t = gen_last + $urandom_range(span);
        send_word(($urandom_range(1) == 1) ? ReqCheck : ReqEdge, t);
      end
    end
  endtask

  task automatic run_random(input int budget);
    int start;
    start = words_sent;
    while (words_sent - start < budget) run_episode();
  endtask

  // Stop sending and let every due frame and the pipeline drain
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // let the monitor log the last accepted word first
    @(posedge clk_i);
    while (due_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegHalfBit: cfg_half = val;
      RegFullBit: cfg_full = val;
      RegTol:     cfg_tol  = val;
      RegEofGap:  cfg_eof  = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_timing(input int h, input int f, input int tol, input int eof);
    drain();
    write_reg(RegHalfBit, h[CfgW-1:0]);
    write_reg(RegFullBit, f[CfgW-1:0]);
    write_reg(RegTol, tol[CfgW-1:0]);
    write_reg(RegEofGap, eof[CfgW-1:0]);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  initial begin
    dir_row_t row;
    result_t  none, frame16;
    int       h, f, tol, eof;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegHalfBit;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ReqEdge;
    pend_typed    = 1'b0;
    pend_emit     = 1'b0;
    pend_res      = '0;
    drv_typed     = 1'b0;
    drv_typed_emit = 1'b0;
    drv_typed_res = '0;
    cfg_half      = HalfBitReset;
    cfg_full      = FullBitReset;
    cfg_tol       = TolReset;
    cfg_eof       = EofGapReset;
    fr_last_edge  = '0;
    fr_level      = 1'b1;
    frame_clear();
    gen_time      = '0;
    gen_last      = '0;
    gen_level     = 1'b1;
    gen_edge_idx  = 0;
    gen_bad_pos   = -1;
    src_idle_pct  = 35;
    dst_idle_pct  = 72;

    none = '0;
    frame16 = '{button_code: NoButton, instance_select: 1'b0, instance_kind: '0,
                source_address: '0, evt_info: '0, evt_flag: 1'b0,
                raw_bits: 26'h5555, bit_count: 5'd16};

    // Directed rows at reset timing: idle check, short frame with window edges
    // and a check right at the gap limit, then sixteen full-bit edges.
    dir_rows.push_back('{ReqCheck, 32'd5000, 1'b1, 1'b0, none});
    dir_rows.push_back('{ReqEdge, 32'd10000, 1'b0, 1'b0, none});
    dir_rows.push_back('{ReqEdge, 32'd10733, 1'b0, 1'b0, none});
    dir_rows.push_back('{ReqEdge, 32'd11050, 1'b0, 1'b0, none});
    dir_rows.push_back('{ReqEdge, 32'd11567, 1'b0, 1'b0, none});
    dir_rows.push_back('{ReqCheck, 32'd13567, 1'b1, 1'b0, none});
    dir_rows.push_back('{ReqCheck, 32'd13568, 1'b1, 1'b0, none});
    dir_rows.push_back('{ReqEdge, 32'd20000, 1'b0, 1'b0, none});
    for (int k = 1; k <= 16; k++)
      dir_rows.push_back('{ReqEdge, 32'(20000 + 833 * k), 1'b0, 1'b0, none});
    dir_rows.push_back('{ReqCheck, 32'd35329, 1'b1, 1'b1, frame16});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      pend_typed = row.typed;
      pend_emit  = row.emit;
      pend_res   = row.res;
      send_word(row.req, row.t);
    end
    pend_typed = 1'b0;
    gen_time = $urandom;

    run_random(250);
    set_timing(1, 2, 0, 1);
    run_random(100);

    src_idle_pct = 72;
    dst_idle_pct = 35;
    set_timing(417, 833, 65535, 65535);
    run_random(150);
    set_timing(65535, 65535, 300, 65535);
    run_random(100);
    set_timing(50, 100, 60, 500);
    run_random(100);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_timing(HalfBitReset, FullBitReset, TolReset, EofGapReset);
    hold_pending = 1;
    run_random(200);
    repeat (2) begin
      h   = $urandom_range(3000, 20);
      f   = 2 * h + $urandom_range(h / 4);
      tol = $urandom_range(h / 3);
      eof = $urandom_range(65535, f + tol + 1);
      set_timing(h, f, tol, eof);
      run_random(175);
    end
    drain();

    $display("Covered %0d input words under %0d timing settings, %0d frames compared.",
             words_sent, settings_count, frames_checked);
    $display("Input was held back for %0d cycles by output stalls.", stall_cycles);
    if (failures == 0) begin
      $display("dali_biphase_frame_receiver verification clean");
    end else begin
      $display("dali_biphase_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dbfr_pkg.sv
sv/dbfr_front.sv
sv/dbfr_queue.sv
sv/dbfr_back.sv
sv/dali_biphase_frame_receiver.sv
test/tb_dali_biphase_frame_receiver.sv
